[sv/mbv_pkg.sv]
`default_nettype none
package mbv_pkg;
    localparam int unsigned MaxDepth = 32;
    localparam int unsigned LvlW = 6;

    typedef logic [31:0] t_word;

    localparam logic [2047:0] RoundK = {
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [255:0] InitH = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    function automatic t_word round_const(input logic [5:0] idx);
        round_const = RoundK[2047 - 32 * idx -: 32];
    endfunction

    function automatic t_word rotr(input t_word x, input int unsigned n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction
endpackage
`default_nettype wire

[sv/merkle_branch_verifier_top.sv]
// Merkle branch verifier, double SHA-256 over raw digest bytes.
// Input channel: i_valid/o_ready with opcode, four hash words, sibling_present
// and current_on_left. Opcode 0 loads the leaf hash and clears the level count;
// opcode 1 climbs one level: the running hash and the sibling (or the running
// hash itself when the sibling is absent) form a 64-byte message that is
// hashed twice, and the digest becomes the running hash.
// Output channel: o_valid/i_ready with the running hash and the level count,
// which stops at 32. One result per item.
// A load passes through ST_LOAD to ST_OUT before its result is offered. A climb
// runs three SHA-256 compressions on one shared round unit, 64 rounds and one
// feed-forward step each, then offers its result in ST_OUT. o_ready returns in
// the cycle after the result is taken. The round unit does one round per cycle.
// One item is in work at a time; o_ready is low until the result has been
// taken. A stalled receiver holds the result and the block waits.
// Reset clears the running hash and the level count to zero.
`default_nettype none
module merkle_branch_verifier_top
    import mbv_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic        i_opcode,
    input  wire logic [63:0] i_hash_word0,
    input  wire logic [63:0] i_hash_word1,
    input  wire logic [63:0] i_hash_word2,
    input  wire logic [63:0] i_hash_word3,
    input  wire logic        i_sibling_present,
    input  wire logic        i_current_on_left,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [63:0]      o_root_word0,
    output logic [63:0]      o_root_word1,
    output logic [63:0]      o_root_word2,
    output logic [63:0]      o_root_word3,
    output logic [LvlW-1:0]  o_level_count
);
    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_LOAD  = 5'b00010,
        ST_ROUND = 5'b00100,
        ST_FEED  = 5'b01000,
        ST_OUT   = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic [255:0] r_hash, n_hash;
    logic [LvlW-1:0] r_lvl, n_lvl;
    logic [511:0] r_w, n_w;
    logic [255:0] r_st, n_st;
    logic [255:0] r_abc, n_abc;
    logic [6:0] r_rnd, n_rnd;
    logic [1:0] r_pass, n_pass;

    t_word a, b, c, d, e, f, g, h, t1, t2, s0, s1, wnew;
    t_word w1, w14, w9, w0;
    logic [255:0] sum_st;
    logic [255:0] in_hash;

    assign in_hash = {i_hash_word0, i_hash_word1, i_hash_word2, i_hash_word3};
    assign o_ready = (r_state == ST_IDLE);
    assign o_valid = (r_state == ST_OUT);
    assign o_root_word0 = r_hash[255:192];
    assign o_root_word1 = r_hash[191:128];
    assign o_root_word2 = r_hash[127:64];
    assign o_root_word3 = r_hash[63:0];
    assign o_level_count = r_lvl;

    always_comb begin
        {a, b, c, d, e, f, g, h} = r_abc;
        w0  = r_w[511:480];
        w1  = r_w[479:448];
        w9  = r_w[223:192];
        w14 = r_w[63:32];
        s0 = rotr(w1, 7) ^ rotr(w1, 18) ^ (w1 >> 3);
        s1 = rotr(w14, 17) ^ rotr(w14, 19) ^ (w14 >> 10);
        wnew = w0 + s0 + w9 + s1;
        t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
            + round_const(r_rnd[5:0]) + w0;
        t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
        for (int k = 0; k < 8; k++) begin
            sum_st[255 - 32 * k -: 32] = r_st[255 - 32 * k -: 32] + r_abc[255 - 32 * k -: 32];
        end
    end

    always_comb begin
        n_state = r_state;
        n_hash  = r_hash;
        n_lvl   = r_lvl;
        n_w     = r_w;
        n_st    = r_st;
        n_abc   = r_abc;
        n_rnd   = r_rnd;
        n_pass  = r_pass;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    if (!i_opcode) begin
                        n_hash  = in_hash;
                        n_lvl   = '0;
                        n_state = ST_LOAD;
                    end else begin
                        if (!i_sibling_present) begin
                            n_w = {r_hash, r_hash};
                        end else if (i_current_on_left) begin
                            n_w = {r_hash, in_hash};
                        end else begin
                            n_w = {in_hash, r_hash};
                        end
                        n_st    = InitH;
                        n_abc   = InitH;
                        n_rnd   = '0;
                        n_pass  = '0;
                        n_state = ST_ROUND;
                    end
                end
            end
            ST_LOAD: begin
                n_state = ST_OUT;
            end
            ST_ROUND: begin
                n_abc = {t1 + t2, a, b, c, d + t1, e, f, g};
                n_w   = {r_w[479:0], wnew};
                n_rnd = r_rnd + 7'd1;
                if (r_rnd == 7'd63) begin
                    n_state = ST_FEED;
                end
            end
            ST_FEED: begin
                n_rnd = '0;
                case (r_pass)
                    2'd0: begin
                        n_st    = sum_st;
                        n_abc   = sum_st;
                        n_w     = {32'h80000000, 448'd0, 32'd512};
                        n_pass  = 2'd1;
                        n_state = ST_ROUND;
                    end
                    2'd1: begin
                        n_st    = InitH;
                        n_abc   = InitH;
                        n_w     = {sum_st, 32'h80000000, 192'd0, 32'd256};
                        n_pass  = 2'd2;
                        n_state = ST_ROUND;
                    end
                    default: begin
                        n_hash  = sum_st;
                        if (r_lvl < LvlW'(MaxDepth)) begin
                            n_lvl = r_lvl + 1'b1;
                        end
                        n_state = ST_OUT;
                    end
                endcase
            end
            ST_OUT: begin
                if (i_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_hash  <= '0;
            r_lvl   <= '0;
            r_rnd   <= '0;
            r_pass  <= '0;
        end else begin
            r_state <= n_state;
            r_hash  <= n_hash;
            r_lvl   <= n_lvl;
            r_rnd   <= n_rnd;
            r_pass  <= n_pass;
        end
        r_w   <= n_w;
        r_st  <= n_st;
        r_abc <= n_abc;
    end
endmodule
`default_nettype wire
